### src/lens_undistort_iterative_macros.svh
// assertion macros shared by the rtl files
// each expects clk and rst_n in the enclosing module
`ifndef LENS_UNDISTORT_ITERATIVE_MACROS_SVH
`define LENS_UNDISTORT_ITERATIVE_MACROS_SVH

// property that must hold in the same cycle as its condition
`define LUD_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// property that must hold in the cycle after its condition
`define LUD_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/lud_pkg.sv
`timescale 1ns / 1ps

package lud_pkg;

    // field widths
    localparam int PIX_W      = 20;
    localparam int FOC_W      = 24;
    localparam int Q_W        = 24;
    localparam int FRAC_W     = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // divider datapath: numerator bits below the first quotient step
    localparam int LSB_W = 4;
    localparam int DEN_W = 32;
    localparam int NUM_W = DEN_W + LSB_W;

    // build defaults
    localparam int ITERATIONS_DEF = 5;
    localparam logic signed [Q_W-1:0] RADIAL_K3_DEF = '0;

    // saturation limits in q4.20 and unity in q12.20
    localparam logic signed [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [DEN_W-1:0] Q_ONE = DEN_W'(1) <<< FRAC_W;

    // register reset values
    localparam logic [FOC_W-1:0] FOCAL_X_RST  = FOC_W'(256000);
    localparam logic [FOC_W-1:0] FOCAL_Y_RST  = FOC_W'(256000);
    localparam logic [PIX_W-1:0] CENTER_X_RST = PIX_W'(163840);
    localparam logic [PIX_W-1:0] CENTER_Y_RST = PIX_W'(122880);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X  = CFG_IDX_W'(0),
        REG_FOCAL_Y  = CFG_IDX_W'(1),
        REG_CENTER_X = CFG_IDX_W'(2),
        REG_CENTER_Y = CFG_IDX_W'(3),
        REG_RAD_K1   = CFG_IDX_W'(4),
        REG_RAD_K2   = CFG_IDX_W'(5),
        REG_TAN_P1   = CFG_IDX_W'(6),
        REG_TAN_P2   = CFG_IDX_W'(7)
    } reg_idx_t;

    // distortion coefficients handed to every iteration
    typedef struct packed {
        logic signed [Q_W-1:0] k1;
        logic signed [Q_W-1:0] k2;
        logic signed [Q_W-1:0] p1;
        logic signed [Q_W-1:0] p2;
    } coef_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] ud;
        logic [LSB_W-1:0] lsb;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             ovf;
        logic             zero;
    } div_lane_t;

endpackage

### src/lud_if.sv
`timescale 1ns / 1ps

// input point channel
interface lud_point_if;
    logic                       valid;
    logic                       ready;
    logic [lud_pkg::PIX_W-1:0]  pixel_x;
    logic [lud_pkg::PIX_W-1:0]  pixel_y;
    logic                       skip_correction;

    modport source (output valid, pixel_x, pixel_y, skip_correction, input ready);
    modport sink (input valid, pixel_x, pixel_y, skip_correction, output ready);
endinterface

// result channel
interface lud_result_if;
    logic                           valid;
    logic                           ready;
    logic signed [lud_pkg::Q_W-1:0] norm_x;
    logic signed [lud_pkg::Q_W-1:0] norm_y;

    modport source (output valid, norm_x, norm_y, input ready);
    modport sink (input valid, norm_x, norm_y, output ready);
endinterface

// register write channel
interface lud_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lud_pkg::CFG_IDX_W-1:0]    index;
    logic [lud_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/lud_div_cell.sv
`timescale 1ns / 1ps
`include "lens_undistort_iterative_macros.svh"

module lud_div_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  lud_pkg::div_lane_t [1:0]            lane_in,
    input  logic [SIDE_W-1:0]                   side_in,
    output logic                                valid_out,
    output lud_pkg::div_lane_t [1:0]            lane_out,
    output logic [SIDE_W-1:0]                   side_out
);

    logic                       valid_reg;
    lud_pkg::div_lane_t [1:0]   lane_reg;
    lud_pkg::div_lane_t [1:0]   lane_next;
    logic [SIDE_W-1:0]          side_reg;

    // one quotient bit per lane: shift in the next numerator bit, try subtract
    always_comb
    begin
        logic [lud_pkg::DEN_W:0] shifted;
        logic [lud_pkg::DEN_W:0] diff;
        shifted = '0;
        diff = '0;
        for (int l = 0; l < 2; l++)
        begin
            shifted = {lane_in[l].rem, lane_in[l].lsb[lud_pkg::LSB_W-1]};
            diff = shifted - {1'b0, lane_in[l].ud};
            lane_next[l] = lane_in[l];
            lane_next[l].lsb = {lane_in[l].lsb[lud_pkg::LSB_W-2:0], 1'b0};
            if (!diff[lud_pkg::DEN_W])
            begin
                lane_next[l].rem = diff[lud_pkg::DEN_W-1:0];
                lane_next[l].quo = {lane_in[l].quo[lud_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[l].rem = shifted[lud_pkg::DEN_W-1:0];
                lane_next[l].quo = {lane_in[l].quo[lud_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;
    assign side_out  = side_reg;

    // partial remainder stays below the divisor for ordinary lanes
    `LUD_ASSERT_NOW(a_rem_lane0, valid_reg && !lane_reg[0].zero && !lane_reg[0].ovf, lane_reg[0].rem < lane_reg[0].ud, "lane 0 remainder not below divisor")
    `LUD_ASSERT_NOW(a_rem_lane1, valid_reg && !lane_reg[1].zero && !lane_reg[1].ovf, lane_reg[1].rem < lane_reg[1].ud, "lane 1 remainder not below divisor")

endmodule

### src/lud_div_pipe.sv
`timescale 1ns / 1ps

module lud_div_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        valid_in,
    input  logic [1:0][lud_pkg::NUM_W-1:0]              num,
    input  logic [1:0][lud_pkg::DEN_W-1:0]              den,
    input  logic [SIDE_W-1:0]                           side_in,
    output logic                                        valid_out,
    output logic [1:0][lud_pkg::Q_W-1:0]                quot,
    output logic [SIDE_W-1:0]                           side_out
);

    localparam int STEPS = lud_pkg::Q_W;

    logic                       setup_valid_reg;
    lud_pkg::div_lane_t [1:0]   setup_lane_reg;
    lud_pkg::div_lane_t [1:0]   setup_lane_next;
    logic [SIDE_W-1:0]          setup_side_reg;

    logic                       chain_valid [STEPS+1];
    lud_pkg::div_lane_t [1:0]   chain_lane [STEPS+1];
    logic [SIDE_W-1:0]          chain_side [STEPS+1];

    logic                               fin_valid_reg;
    logic [1:0][lud_pkg::Q_W-1:0]       fin_quot_reg;
    logic [1:0][lud_pkg::Q_W-1:0]       fin_quot_next;
    logic [SIDE_W-1:0]                  fin_side_reg;

    // setup: magnitudes, sign, zero numerator, overflow and zero divisor
    always_comb
    begin
        logic [lud_pkg::NUM_W-1:0] un;
        logic [lud_pkg::DEN_W-1:0] ud;
        logic n_neg;
        logic d_neg;
        logic n_zero;
        logic d_zero;
        un = '0;
        ud = '0;
        n_neg = 1'b0;
        d_neg = 1'b0;
        n_zero = 1'b0;
        d_zero = 1'b0;
        for (int l = 0; l < 2; l++)
        begin
            n_neg  = num[l][lud_pkg::NUM_W-1];
            d_neg  = den[l][lud_pkg::DEN_W-1];
            n_zero = (num[l] == '0);
            d_zero = (den[l] == '0);
            un = n_neg ? (~num[l] + 1'b1) : num[l];
            ud = d_neg ? (~den[l] + 1'b1) : den[l];
            setup_lane_next[l].rem  = un[lud_pkg::LSB_W +: lud_pkg::DEN_W];
            setup_lane_next[l].ud   = ud;
            setup_lane_next[l].lsb  = un[lud_pkg::LSB_W-1:0];
            setup_lane_next[l].quo  = '0;
            setup_lane_next[l].zero = n_zero;
            setup_lane_next[l].neg  = d_zero ? n_neg : (n_neg ^ d_neg);
            setup_lane_next[l].ovf  = !n_zero &&
                (d_zero || (un >= {ud, {lud_pkg::LSB_W{1'b0}}}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_valid_reg <= 1'b0;
        else if (en)
            setup_valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setup_lane_reg <= setup_lane_next;
            setup_side_reg <= side_in;
        end
    end

    assign chain_valid[0] = setup_valid_reg;
    assign chain_lane[0]  = setup_lane_reg;
    assign chain_side[0]  = setup_side_reg;

    // one cell per quotient bit, most significant first
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        lud_div_cell #(
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (chain_valid[s]),
            .lane_in   (chain_lane[s]),
            .side_in   (chain_side[s]),
            .valid_out (chain_valid[s+1]),
            .lane_out  (chain_lane[s+1]),
            .side_out  (chain_side[s+1])
        );
    end

    // sign and saturation of the quotient
    always_comb
    begin
        lud_pkg::div_lane_t ln;
        ln = '0;
        for (int l = 0; l < 2; l++)
        begin
            ln = chain_lane[STEPS][l];
            if (ln.zero)
                fin_quot_next[l] = '0;
            else if (ln.ovf)
                fin_quot_next[l] = ln.neg ? lud_pkg::SAT_MIN : lud_pkg::SAT_MAX;
            else if (ln.neg)
                fin_quot_next[l] = ln.quo[lud_pkg::Q_W-1] ? lud_pkg::SAT_MIN
                                                         : (~ln.quo + 1'b1);
            else
                fin_quot_next[l] = ln.quo[lud_pkg::Q_W-1] ? lud_pkg::SAT_MAX : ln.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (en)
            fin_valid_reg <= chain_valid[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_quot_reg <= fin_quot_next;
            fin_side_reg <= chain_side[STEPS];
        end
    end

    assign valid_out = fin_valid_reg;
    assign quot      = fin_quot_reg;
    assign side_out  = fin_side_reg;

endmodule

### src/lud_iter_cell.sv
`timescale 1ns / 1ps

module lud_iter_cell #(
    parameter logic signed [lud_pkg::Q_W-1:0] RADIAL_K3 = lud_pkg::RADIAL_K3_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  lud_pkg::coef_t                  coef,
    input  logic                            valid_in,
    input  logic signed [lud_pkg::Q_W-1:0]  x_in,
    input  logic signed [lud_pkg::Q_W-1:0]  y_in,
    input  logic [2*lud_pkg::Q_W:0]         side_in,
    output logic                            valid_out,
    output logic signed [lud_pkg::Q_W-1:0]  x_out,
    output logic signed [lud_pkg::Q_W-1:0]  y_out,
    output logic [2*lud_pkg::Q_W:0]         side_out
);

    localparam int QW   = lud_pkg::Q_W;
    localparam int FW   = lud_pkg::FRAC_W;
    localparam int NW   = lud_pkg::NUM_W;
    localparam int DW   = lud_pkg::DEN_W;
    localparam int SW   = 2*QW + 1;
    localparam int XX_W = 2*QW - 1 - FW;
    localparam int XY_W = 2*QW - FW;
    localparam int RS_W = XX_W + 1;
    localparam int A_W  = XX_W + 2;
    localparam int T1_W = QW + XY_W - FW;
    localparam int T2_W = QW + A_W + 1 - FW;
    localparam int TK_W = 2*QW + 1 - FW;
    localparam int NS   = 6;

    // valid bits of the front stages
    logic [NS-1:0] v_reg;
    logic [SW-1:0] side_reg [NS];

    // stage 1
    logic [XX_W-1:0]        xx1_reg, yy1_reg, xx1_next, yy1_next;
    logic signed [XY_W-1:0] xy1_reg, xy1_next;
    // stage 2
    logic [XX_W-1:0]        xx2_reg, yy2_reg;
    logic signed [XY_W-1:0] xy2_reg;
    logic [QW-1:0]          r1_2_reg, r1_2_next;
    // stage 3
    logic signed [XY_W-1:0] xy3_reg;
    logic [QW-1:0]          r1_3_reg, r2_3_reg, r2_3_next;
    logic [A_W-1:0]         a1_3_reg, a2_3_reg, a1_3_next, a2_3_next;
    // stage 4
    logic [QW-1:0]          r3_4_reg, r3_4_next;
    logic signed [T1_W-1:0] t1_reg, t3_reg, t1_next, t3_next;
    logic signed [T2_W-1:0] t2_reg, t4_reg, t2_next, t4_next;
    logic signed [TK_W-1:0] tk1_reg, tk2_reg, tk1_next, tk2_next;
    // stage 5
    logic signed [NW-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [TK_W-1:0] tk3_reg, tk3_next;
    logic signed [DW-1:0]   radp_reg, radp_next;
    // stage 6
    logic signed [NW-1:0]   numx_reg, numy_reg, numx_next, numy_next;
    logic signed [DW-1:0]   rad_reg, rad_next;

    logic signed [QW-1:0]   x0_6, y0_6;
    logic [1:0][QW-1:0]     quot;

    // squares and cross product
    always_comb
    begin
        logic signed [2*QW-1:0] pxx;
        logic signed [2*QW-1:0] pyy;
        logic signed [2*QW-1:0] pxy;
        pxx = x_in * x_in;
        pyy = y_in * y_in;
        pxy = x_in * y_in;
        xx1_next = pxx[2*QW-2:FW];
        yy1_next = pyy[2*QW-2:FW];
        xy1_next = pxy[2*QW-1:FW];
    end

    // radius squared, capped
    always_comb
    begin
        logic [RS_W-1:0] sum;
        sum = {1'b0, xx1_reg} + {1'b0, yy1_reg};
        r1_2_next = (|sum[RS_W-1:QW-1]) ? lud_pkg::SAT_MAX : sum[QW-1:0];
    end

    // r^4 and the tangential sums
    always_comb
    begin
        logic [2*QW-1:0] prod;
        prod = r1_2_reg * r1_2_reg;
        r2_3_next = (|prod[2*QW-1:FW+QW-1]) ? lud_pkg::SAT_MAX : prod[FW+QW-1:FW];
        a1_3_next = A_W'(r1_2_reg) + (A_W'(xx2_reg) << 1);
        a2_3_next = A_W'(r1_2_reg) + (A_W'(yy2_reg) << 1);
    end

    // r^6 and the coefficient products
    always_comb
    begin
        logic [2*QW-1:0] prod;
        logic signed [QW+XY_W-1:0] m1;
        logic signed [QW+XY_W-1:0] m3;
        logic signed [QW+A_W:0] m2;
        logic signed [QW+A_W:0] m4;
        logic signed [2*QW:0] mk1;
        logic signed [2*QW:0] mk2;
        prod = r2_3_reg * r1_3_reg;
        r3_4_next = (|prod[2*QW-1:FW+QW-1]) ? lud_pkg::SAT_MAX : prod[FW+QW-1:FW];
        m1  = $signed(coef.p1) * xy3_reg;
        m3  = $signed(coef.p2) * xy3_reg;
        m2  = $signed(coef.p2) * $signed({1'b0, a1_3_reg});
        m4  = $signed(coef.p1) * $signed({1'b0, a2_3_reg});
        mk1 = $signed(coef.k1) * $signed({1'b0, r1_3_reg});
        mk2 = $signed(coef.k2) * $signed({1'b0, r2_3_reg});
        t1_next  = m1[QW+XY_W-1:FW];
        t3_next  = m3[QW+XY_W-1:FW];
        t2_next  = m2[QW+A_W:FW];
        t4_next  = m4[QW+A_W:FW];
        tk1_next = mk1[2*QW:FW];
        tk2_next = mk2[2*QW:FW];
    end

    // distortion offsets and partial radial factor
    always_comb
    begin
        logic signed [2*QW:0] mk3;
        mk3 = RADIAL_K3 * $signed({1'b0, r3_4_reg});
        tk3_next  = mk3[2*QW:FW];
        dx_next   = (NW'(t1_reg) <<< 1) + NW'(t2_reg);
        dy_next   = (NW'(t3_reg) <<< 1) + NW'(t4_reg);
        radp_next = lud_pkg::Q_ONE + DW'(tk1_reg) + DW'(tk2_reg);
    end

    // divider operands
    assign x0_6 = side_reg[NS-2][2*QW-1:QW];
    assign y0_6 = side_reg[NS-2][QW-1:0];

    always_comb
    begin
        numx_next = NW'(x0_6) - dx_reg;
        numy_next = NW'(y0_6) - dy_reg;
        rad_next  = radp_reg + DW'(tk3_reg);
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], valid_in};
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < NS; s++)
                side_reg[s] <= side_reg[s-1];
            xx1_reg  <= xx1_next;
            yy1_reg  <= yy1_next;
            xy1_reg  <= xy1_next;
            xx2_reg  <= xx1_reg;
            yy2_reg  <= yy1_reg;
            xy2_reg  <= xy1_reg;
            r1_2_reg <= r1_2_next;
            xy3_reg  <= xy2_reg;
            r1_3_reg <= r1_2_reg;
            r2_3_reg <= r2_3_next;
            a1_3_reg <= a1_3_next;
            a2_3_reg <= a2_3_next;
            r3_4_reg <= r3_4_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            t3_reg   <= t3_next;
            t4_reg   <= t4_next;
            tk1_reg  <= tk1_next;
            tk2_reg  <= tk2_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            tk3_reg  <= tk3_next;
            radp_reg <= radp_next;
            numx_reg <= numx_next;
            numy_reg <= numy_next;
            rad_reg  <= rad_next;
        end
    end

    // both coordinates share the radial divisor
    lud_div_pipe #(
        .SIDE_W (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v_reg[NS-1]),
        .num       ({numy_reg, numx_reg}),
        .den       ({rad_reg, rad_reg}),
        .side_in   (side_reg[NS-1]),
        .valid_out (valid_out),
        .quot      (quot),
        .side_out  (side_out)
    );

    assign x_out = quot[0];
    assign y_out = quot[1];

endmodule

### src/lens_undistort_iterative.sv
// iterative lens undistortion of one sub-pixel image point per transaction
//
// channels: point (pixel_x, pixel_y in q12.8, skip_correction) in, result
// (norm_x, norm_y in signed q4.20, saturated) out, both valid/ready;
// cfg writes register index and data, always ready; write it only while
// no point is in flight, since the registers feed every stage directly
//
// the point is normalized by a 26-stage divider (setup, 24 restoring cells
// of one quotient bit each, sign and saturation), then passes ITERATIONS
// identical iteration stages; each has 6 multiply/add stages followed by
// its own 26-stage divider chain
// in all, 26 + 32 * ITERATIONS register stages lie between point and result;
// one point is accepted every cycle while the result is not stalled
//
// the whole chain advances together: when result is held by a stalled
// receiver, point.ready drops and every stage holds its contents
// reset clears all valid bits and loads the register defaults; the block
// is ready as soon as reset is released
`timescale 1ns / 1ps
`include "lens_undistort_iterative_macros.svh"

module lens_undistort_iterative #(
    parameter int ITERATIONS = lud_pkg::ITERATIONS_DEF,
    parameter logic signed [lud_pkg::Q_W-1:0] RADIAL_K3 = lud_pkg::RADIAL_K3_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    lud_cfg_if.sink         cfg,
    lud_point_if.sink       point,
    lud_result_if.source    result
);

    localparam int QW = lud_pkg::Q_W;
    localparam int NW = lud_pkg::NUM_W;
    localparam int DW = lud_pkg::DEN_W;
    localparam int SW = 2*QW + 1;

    logic [lud_pkg::FOC_W-1:0]  focal_x_reg, focal_y_reg;
    logic [lud_pkg::PIX_W-1:0]  center_x_reg, center_y_reg;
    lud_pkg::coef_t             coef_reg;

    logic                       en;
    logic                       norm_valid;
    logic [1:0][QW-1:0]         norm_quot;
    logic                       norm_skip;

    logic                       it_valid [ITERATIONS+1];
    logic signed [QW-1:0]       it_x [ITERATIONS+1];
    logic signed [QW-1:0]       it_y [ITERATIONS+1];
    logic [SW-1:0]              it_side [ITERATIONS+1];

    logic signed [NW-1:0]       num_x, num_y;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= lud_pkg::FOCAL_X_RST;
            focal_y_reg  <= lud_pkg::FOCAL_Y_RST;
            center_x_reg <= lud_pkg::CENTER_X_RST;
            center_y_reg <= lud_pkg::CENTER_Y_RST;
            coef_reg     <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lud_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg.data[lud_pkg::FOC_W-1:0];
                lud_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg.data[lud_pkg::FOC_W-1:0];
                lud_pkg::REG_CENTER_X: center_x_reg <= cfg.data[lud_pkg::PIX_W-1:0];
                lud_pkg::REG_CENTER_Y: center_y_reg <= cfg.data[lud_pkg::PIX_W-1:0];
                lud_pkg::REG_RAD_K1:   coef_reg.k1  <= cfg.data[QW-1:0];
                lud_pkg::REG_RAD_K2:   coef_reg.k2  <= cfg.data[QW-1:0];
                lud_pkg::REG_TAN_P1:   coef_reg.p1  <= cfg.data[QW-1:0];
                lud_pkg::REG_TAN_P2:   coef_reg.p2  <= cfg.data[QW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // whole chain moves unless the result is stalled
    assign en          = !result.valid || result.ready;
    assign point.ready = en;

    // normalization operands
    assign num_x = NW'($signed({1'b0, point.pixel_x})) - NW'($signed({1'b0, center_x_reg}));
    assign num_y = NW'($signed({1'b0, point.pixel_y})) - NW'($signed({1'b0, center_y_reg}));

    lud_div_pipe #(
        .SIDE_W (1)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (point.valid),
        .num       ({num_y, num_x}),
        .den       ({DW'(focal_y_reg), DW'(focal_x_reg)}),
        .side_in   (point.skip_correction),
        .valid_out (norm_valid),
        .quot      (norm_quot),
        .side_out  (norm_skip)
    );

    assign it_valid[0] = norm_valid;
    assign it_x[0]     = norm_quot[0];
    assign it_y[0]     = norm_quot[1];
    assign it_side[0]  = {norm_skip, norm_quot[0], norm_quot[1]};

    // one stage per fixed-point iteration
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        lud_iter_cell #(
            .RADIAL_K3 (RADIAL_K3)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .coef      (coef_reg),
            .valid_in  (it_valid[i]),
            .x_in      (it_x[i]),
            .y_in      (it_y[i]),
            .side_in   (it_side[i]),
            .valid_out (it_valid[i+1]),
            .x_out     (it_x[i+1]),
            .y_out     (it_y[i+1]),
            .side_out  (it_side[i+1])
        );
    end

    // skipped points return the normalized coordinates
    assign result.valid  = it_valid[ITERATIONS];
    assign result.norm_x = it_side[ITERATIONS][SW-1] ? it_side[ITERATIONS][2*QW-1:QW]
                                                     : it_x[ITERATIONS];
    assign result.norm_y = it_side[ITERATIONS][SW-1] ? it_side[ITERATIONS][QW-1:0]
                                                     : it_y[ITERATIONS];

    `LUD_ASSERT_NEXT(a_focal_x_write, cfg.valid && cfg.ready && cfg.index == lud_pkg::REG_FOCAL_X, focal_x_reg == $past(cfg.data), "focal_x write not taken")
    `LUD_ASSERT_NEXT(a_k1_write, cfg.valid && cfg.ready && cfg.index == lud_pkg::REG_RAD_K1, coef_reg.k1 == $past(cfg.data), "radial_k1 write not taken")

endmodule
